// ----- rtl/sdeq_pkg.sv -----
// ----------------------------------------------------------------------------
// sdeq_pkg
// Shared types and codes for the sorted double-ended queue and its cell row.
// ----------------------------------------------------------------------------
package sdeq_pkg;

  // Width of one stored entry and of the request value.
  localparam int unsigned DATA_W = 32;

  // Operation codes carried by a request.
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_TAKE_MIN = 2'd1,
    OP_TAKE_MAX = 2'd2,
    OP_SEARCH   = 2'd3
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast to every cell in the row.
  typedef struct packed {
    logic                     ins;
    logic                     take_min;
    logic                     take_max;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // What one cell shows to its neighbors and to the top level.
  typedef struct packed {
    logic                     valid;
    logic                     gt;
    logic                     match;
    logic signed [DATA_W-1:0] entry;
  } link_t;

endpackage

// ----- rtl/sdeq_cell.sv -----
// ----------------------------------------------------------------------------
// sdeq_cell
// One slot of the sorted row: holds one entry, compares it with the request
// value and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module sdeq_cell (
  input  logic           clk,
  input  logic           rst,
  input  sdeq_pkg::cmd_t  cmd,
  input  sdeq_pkg::link_t left,
  input  sdeq_pkg::link_t right,
  output sdeq_pkg::link_t self
);

  logic                              valid;
  logic                              valid_next;
  logic signed [sdeq_pkg::DATA_W-1:0] entry;
  logic signed [sdeq_pkg::DATA_W-1:0] entry_next;
  logic                              gt;
  logic                              match;

  // Local compares against the broadcast value.
  always_comb begin
    gt    = valid && (entry > cmd.value);
    match = valid && (entry == cmd.value);
  end

  // Next contents. An insert shifts every entry above the value one slot to
  // the right; the first slot that is greater, or the first empty one, takes
  // the new value. A take-min shifts everything one slot to the left, and a
  // take-max drops the last valid slot.
  always_comb begin
    entry_next = entry;
    valid_next = valid;
    if (cmd.ins) begin
      if (left.gt) begin
        entry_next = left.entry;
        valid_next = 1'b1;
      end else if (left.valid && (gt || !valid)) begin
        entry_next = cmd.value;
        valid_next = 1'b1;
      end
    end else if (cmd.take_min) begin
      entry_next = right.entry;
      valid_next = right.valid;
    end else if (cmd.take_max) begin
      valid_next = valid && right.valid;
    end
  end

  // Valid bit is control state; the entry itself needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign self.valid = valid;
  assign self.gt    = gt;
  assign self.match = match;
  assign self.entry = entry;

endmodule

// ----- rtl/sorted_double_ended_queue_unit.sv -----
// ----------------------------------------------------------------------------
// The result of each accepted request is held in the output register.
// Throughput: one request per cycle; the whole cell row compares and shifts
// in the same cycle. A new request enters in the cycle the previous result is
// taken, and a stalled result holds off the input. Reset clears the output
// valid, the entry count and every cell's valid bit; entries are not cleared.
// ----------------------------------------------------------------------------
// sorted_double_ended_queue_unit
// Sorted store of signed entries with insert, take-min, take-max and search,
// built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
module sorted_double_ended_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        kind,
  input  logic signed [sdeq_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [sdeq_pkg::DATA_W-1:0] result_value,
  output logic                              found,
  output logic [4:0]                        entry_count
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                              accept;
  sdeq_pkg::kind_t                   op;
  sdeq_pkg::cmd_t                    cmd;
  sdeq_pkg::link_t                   cells [DEPTH];
  logic [CW-1:0]                     count;
  logic [CW-1:0]                     count_next;
  logic                              is_full;
  logic                              is_empty;
  logic signed [sdeq_pkg::DATA_W-1:0] max_val;
  logic                              any_match;
  logic [1:0]                        status_next;
  logic signed [sdeq_pkg::DATA_W-1:0] result_next;
  logic                              found_next;
  logic [CW+4:0]                     count_ext;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = sdeq_pkg::kind_t'(kind);
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);

  // Broadcast command; only operations that change the store are issued.
  always_comb begin
    cmd.value    = value;
    cmd.ins      = accept && (op == sdeq_pkg::OP_INSERT) && !is_full;
    cmd.take_min = accept && (op == sdeq_pkg::OP_TAKE_MIN) && !is_empty;
    cmd.take_max = accept && (op == sdeq_pkg::OP_TAKE_MAX) && !is_empty;
  end

  // Row of cells, each wired to its two neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sdeq_pkg::link_t left_in;
    sdeq_pkg::link_t right_in;

    if (i == 0) begin : g_first
      assign left_in = '{valid: 1'b1, gt: 1'b0, match: 1'b0, entry: '0};
    end else begin : g_mid_l
      assign left_in = cells[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_in = '{valid: 1'b0, gt: 1'b0, match: 1'b0, entry: '0};
    end else begin : g_mid_r
      assign right_in = cells[i+1];
    end

    sdeq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .left  (left_in),
      .right (right_in),
      .self  (cells[i])
    );
  end

  // Largest entry is the last valid cell; search hits if any cell matches.
  always_comb begin
    max_val   = '0;
    any_match = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cells[i].valid && ((i == DEPTH - 1) || !cells[(i + 1) % DEPTH].valid)) begin
        max_val = max_val | cells[i].entry;
      end
      any_match = any_match | cells[i].match;
    end
  end

  // Result of the accepted request.
  always_comb begin
    status_next = sdeq_pkg::ST_DONE;
    result_next = '0;
    found_next  = 1'b0;
    count_next  = count;
    case (op)
      sdeq_pkg::OP_INSERT: begin
        if (is_full) begin
          status_next = sdeq_pkg::ST_FULL;
        end else begin
          result_next = value;
          count_next  = count + CW'(1);
        end
      end
      sdeq_pkg::OP_TAKE_MIN: begin
        if (is_empty) begin
          status_next = sdeq_pkg::ST_EMPTY;
        end else begin
          result_next = cells[0].entry;
          count_next  = count - CW'(1);
        end
      end
      sdeq_pkg::OP_TAKE_MAX: begin
        if (is_empty) begin
          status_next = sdeq_pkg::ST_EMPTY;
        end else begin
          result_next = max_val;
          count_next  = count - CW'(1);
        end
      end
      default: begin
        found_next = any_match;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
        count     <= count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= status_next;
      result_value <= result_next;
      found        <= found_next;
      entry_count  <= count_ext[4:0];
    end
  end

  assign count_ext = {5'b0, count_next};

endmodule

// ----- rtl/sdeq_checker.sv -----
// ----------------------------------------------------------------------------
// sdeq_checker
// Port-level checks for the sorted double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module sdeq_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [1:0]                        kind,
  input logic signed [sdeq_pkg::DATA_W-1:0] value,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        status,
  input logic signed [sdeq_pkg::DATA_W-1:0] result_value,
  input logic                              found,
  input logic [4:0]                        entry_count
);

  localparam logic [31:0] DEPTH_W = 32'(DEPTH);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
    else $error("stalled result changed");

  // No result is shown right after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // An empty report means nothing is stored and nothing is returned.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == sdeq_pkg::ST_EMPTY) |-> (entry_count == 5'd0) && (result_value == '0))
    else $error("empty report inconsistent");

  // A full report comes with the full count and no value.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == sdeq_pkg::ST_FULL)
      |-> (entry_count == DEPTH_W[4:0]) && (result_value == '0) && !found)
    else $error("full report inconsistent");

  // A hit is reported only with a done status and no value.
  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> (status == sdeq_pkg::ST_DONE) && (result_value == '0))
    else $error("search hit inconsistent");

endmodule

bind sorted_double_ended_queue_unit sdeq_checker #(.DEPTH(DEPTH)) u_sdeq_checker (.*);

// ----- tb/sv/sdeq_result_checker.sv -----
// ----------------------------------------------------------------------------
// sdeq_result_checker
// Watches both channels of the sorted double-ended queue. It keeps its own
// sorted copy of the stored entries, works out the result of every accepted
// request, and compares each accepted result with the oldest one waiting.
// ----------------------------------------------------------------------------
module sdeq_result_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [1:0]                         kind,
  input  logic signed [sdeq_pkg::DATA_W-1:0] value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [1:0]                         status,
  input  logic signed [sdeq_pkg::DATA_W-1:0] result_value,
  input  logic                               found,
  input  logic [4:0]                         entry_count,
  output int unsigned                        mismatches,
  output int unsigned                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // One result as the block should report it, tagged with its operation.
  typedef struct packed {
    sdeq_pkg::kind_t                    op;
    sdeq_pkg::status_t                  status;
    logic signed [sdeq_pkg::DATA_W-1:0] result_value;
    logic                               found;
    logic [4:0]                         entry_count;
  } outcome_t;

  // Shadow copy of the store, ascending, valid below held_count.
  logic signed [sdeq_pkg::DATA_W-1:0] held_entries [DEPTH];
  int                                 held_count;

  outcome_t    pending_outcomes [$];
  int unsigned error_count = 0;

  // Applies one request to the shadow store and returns the result it causes.
  function automatic outcome_t apply_operation(sdeq_pkg::kind_t op,
                                               logic signed [sdeq_pkg::DATA_W-1:0] v);
    outcome_t o;
    int       pos;
    o.op           = op;
    o.status       = sdeq_pkg::ST_DONE;
    o.result_value = '0;
    o.found        = 1'b0;
    case (op)
      sdeq_pkg::OP_INSERT: begin
        if (held_count >= DEPTH) begin
          o.status = sdeq_pkg::ST_FULL;
        end else begin
          // New entry goes after every entry that is not greater than it.
          pos = held_count;
          for (int i = 0; i < held_count; i++) begin
            if (held_entries[i] > v) begin
              pos = i;
              break;
            end
          end
          for (int i = held_count; i > pos; i--) held_entries[i] = held_entries[i-1];
          held_entries[pos] = v;
          held_count++;
          o.result_value = v;
        end
      end
      sdeq_pkg::OP_TAKE_MIN: begin
        if (held_count == 0) begin
          o.status = sdeq_pkg::ST_EMPTY;
        end else begin
          o.result_value = held_entries[0];
          for (int i = 1; i < held_count; i++) held_entries[i-1] = held_entries[i];
          held_count--;
        end
      end
      sdeq_pkg::OP_TAKE_MAX: begin
        if (held_count == 0) begin
          o.status = sdeq_pkg::ST_EMPTY;
        end else begin
          o.result_value = held_entries[held_count-1];
          held_count--;
        end
      end
      default: begin
        for (int i = 0; i < held_count; i++) begin
          if (held_entries[i] == v) begin
            o.found = 1'b1;
            break;
          end
        end
      end
    endcase
    o.entry_count = 5'(held_count);
    return o;
  endfunction

  task automatic note_failure(string what);
    if (error_count < 10) $display("%0t ns: %s", $time, what);
    error_count++;
  endtask

  // Results are compared before the request of the same edge is predicted,
  // since a result always belongs to an earlier request.
  always @(posedge clk) begin : watch
    outcome_t want;
    outcome_t got;
    if (rst) begin
      pending_outcomes.delete();
      held_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.status       = sdeq_pkg::status_t'(status);
        got.result_value = result_value;
        got.found        = found;
        got.entry_count  = entry_count;
        if (pending_outcomes.size() == 0) begin
          note_failure($sformatf("result with no request waiting: status=%0d value=%0d",
                                 status, result_value));
        end else begin
          want   = pending_outcomes.pop_front();
          got.op = want.op;
          if (got.status !== want.status || got.result_value !== want.result_value ||
              got.found !== want.found || got.entry_count !== want.entry_count) begin
            note_failure($sformatf({"%s mismatch: status %0d/%0d value %0d/%0d ",
                                    "found %0d/%0d count %0d/%0d (actual/expected)"},
                                   want.op.name(), got.status, want.status,
                                   got.result_value, want.result_value,
                                   got.found, want.found, got.entry_count, want.entry_count));
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_outcomes.push_back(apply_operation(sdeq_pkg::kind_t'(kind), value));
      end
    end
    mismatches  <= error_count;
    outstanding <= pending_outcomes.size();
  end

endmodule

// ----- tb/sv/tb_sorted_double_ended_queue_unit.sv -----
// ----------------------------------------------------------------------------
// tb_sorted_double_ended_queue_unit
// Drives directed and random insert, take-min, take-max and search requests
// into the sorted queue with random idling on both channels, and gives the
// verdict from the failure count of the result checker.
// ----------------------------------------------------------------------------
module tb_sorted_double_ended_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned QUIET_LIMIT  = 2000;

  // Operation mixes used by the random phases.
  typedef enum int unsigned {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_LOOKUP} mix_t;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               in_valid;
  logic                               in_ready;
  logic [1:0]                         kind;
  logic signed [sdeq_pkg::DATA_W-1:0] value;
  logic                               out_valid;
  logic                               out_ready;
  logic [1:0]                         status;
  logic signed [sdeq_pkg::DATA_W-1:0] result_value;
  logic                               found;
  logic [4:0]                         entry_count;
  int unsigned                        mismatch_total;
  int unsigned                        results_pending;

  always #5 clk = ~clk;

  sorted_double_ended_queue_unit #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .result_value(result_value), .found(found), .entry_count(entry_count)
  );

  sdeq_result_checker #(.DEPTH(DEPTH)) u_result_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .result_value(result_value), .found(found), .entry_count(entry_count),
    .mismatches(mismatch_total), .outstanding(results_pending)
  );

  function automatic sdeq_pkg::kind_t pick_kind(mix_t mix);
    int unsigned r, ins_w, min_w, max_w;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:   begin ins_w = 70; min_w = 10; max_w = 10; end
      MIX_DRAIN:  begin ins_w = 15; min_w = 35; max_w = 35; end
      MIX_LOOKUP: begin ins_w = 25; min_w = 10; max_w = 10; end
      default:    begin ins_w = 35; min_w = 20; max_w = 20; end
    endcase
    if (r < ins_w) return sdeq_pkg::OP_INSERT;
    if (r < ins_w + min_w) return sdeq_pkg::OP_TAKE_MIN;
    if (r < ins_w + min_w + max_w) return sdeq_pkg::OP_TAKE_MAX;
    return sdeq_pkg::OP_SEARCH;
  endfunction

  // Small values give duplicates and search hits; the rest spread over the range.
  function automatic logic signed [sdeq_pkg::DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $signed($urandom_range(0, 15)) - 8;
    if (r < 75) return $urandom();
    if (r < 85) return 32'sh7fffffff - $urandom_range(0, 3);
    if (r < 95) return 32'sh80000000 + $urandom_range(0, 3);
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  // Mostly no gap, some short ones and a few long ones.
  function automatic int unsigned pick_gap(bit gaps_on);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one request and holds it until the block accepts it.
  task automatic send_request(sdeq_pkg::kind_t op, logic signed [sdeq_pkg::DATA_W-1:0] v,
                              int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= op;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // Request source: reset, directed cases, then random phases.
  initial begin : request_source
    mix_t        mix;
    int unsigned sent, len;
    bit          gaps_on;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    kind     <= sdeq_pkg::OP_INSERT;
    value    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Removals and search on an empty store.
    send_request(sdeq_pkg::OP_TAKE_MIN, pick_value(), 0);
    send_request(sdeq_pkg::OP_TAKE_MAX, pick_value(), 0);
    send_request(sdeq_pkg::OP_SEARCH, 32'sd0, 0);
    // Extremes, zero, minus one and a duplicated value.
    send_request(sdeq_pkg::OP_INSERT, 32'sh7fffffff, 0);
    send_request(sdeq_pkg::OP_INSERT, 32'sh80000000, 1);
    send_request(sdeq_pkg::OP_INSERT, 32'sd0, 0);
    send_request(sdeq_pkg::OP_INSERT, -32'sd1, 0);
    send_request(sdeq_pkg::OP_INSERT, 32'sd7, 2);
    send_request(sdeq_pkg::OP_INSERT, 32'sd7, 0);
    // Search hits and a miss.
    send_request(sdeq_pkg::OP_SEARCH, 32'sd7, 0);
    send_request(sdeq_pkg::OP_SEARCH, 32'sd8, 0);
    send_request(sdeq_pkg::OP_SEARCH, 32'sh80000000, 0);
    send_request(sdeq_pkg::OP_SEARCH, 32'sh7fffffff, 0);
    // Take from both ends down to the last entry, then empty it.
    send_request(sdeq_pkg::OP_TAKE_MIN, pick_value(), 0);
    send_request(sdeq_pkg::OP_TAKE_MAX, pick_value(), 0);
    send_request(sdeq_pkg::OP_TAKE_MIN, pick_value(), 0);
    send_request(sdeq_pkg::OP_TAKE_MAX, pick_value(), 1);
    send_request(sdeq_pkg::OP_TAKE_MIN, pick_value(), 0);
    send_request(sdeq_pkg::OP_TAKE_MAX, pick_value(), 0);
    send_request(sdeq_pkg::OP_TAKE_MAX, pick_value(), 0);
    send_request(sdeq_pkg::OP_SEARCH, 32'sd7, 0);
    wait_for_results();

    // Random phases; the store persists across them, so fill phases reach
    // the full case and drain phases the empty one.
    sent = 0;
    mix  = MIX_FILL;
    while (sent < RANDOM_ITEMS) begin
      len     = $urandom_range(20, 70);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (len) begin
        send_request(pick_kind(mix), pick_value(), pick_gap(gaps_on));
        sent++;
      end
      wait_for_results();
      mix = mix_t'($urandom_range(0, 3));
    end

    repeat (5) @(posedge clk);
    if (mismatch_total == 0 && results_pending == 0) begin
      $display("tb_sorted_double_ended_queue_unit OK");
    end else begin
      $display("tb_sorted_double_ended_queue_unit NOT OK");
    end
    $finish;
  end

  // Result sink: random stalls, steady stretches, and long hold-offs that
  // back the block up into its input while requests keep coming.
  initial begin : result_sink
    int unsigned taken, stall_left, steady_left, hold_mark, r;
    taken       = 0;
    stall_left  = 0;
    steady_left = 0;
    hold_mark   = 120;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (taken >= hold_mark) begin
        stall_left  = 80;
        steady_left = 0;
        hold_mark   = hold_mark + 330;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (steady_left > 0) begin
        steady_left--;
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
        end else if (r < 90) begin
          stall_left = $urandom_range(0, 2);
          out_ready <= 1'b0;
        end else if (r < 95) begin
          stall_left = $urandom_range(8, 40);
          out_ready <= 1'b0;
        end else begin
          steady_left = $urandom_range(20, 100);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_sorted_double_ended_queue_unit NOT OK");
    $finish;
  end

endmodule
